FILE: sv/hpt_pkg.sv
package hpt_pkg;

	localparam int COUNTER_BITS  = 16;
	localparam int FRACTION_BITS = 8;

	localparam int TIMER_W   = COUNTER_BITS;
	localparam int WRAP_W    = 32;
	localparam int PERIOD_W  = 32;
	localparam int NUM_W     = 32;
	localparam int LIM_W     = 16;
	localparam int SCALE_W   = 24;
	localparam int SPD_W     = 24;
	localparam int ACC_W     = 26;
	localparam int PROD_W    = SPD_W + SCALE_W;
	localparam int DIV_W     = PROD_W;
	localparam int SPD_DVD_W = NUM_W + FRACTION_BITS;
	localparam int STEP_W    = $clog2(DIV_W + 1);
	localparam int MUL_CNT_W = $clog2(SCALE_W + 1);

	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 56;
	localparam int OUT_PAD_W   = OUT_TDATA_W - SPD_W - ACC_W;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [1:0] REG_SPEED_NUM   = 2'd0;
	localparam logic [1:0] REG_SPEED_LIM   = 2'd1;
	localparam logic [1:0] REG_ACCEL_SCALE = 2'd2;

	localparam logic [NUM_W-1:0]   SPEED_NUM_RST   = 32'd436363636;
	localparam logic [LIM_W-1:0]   SPEED_LIM_RST   = 16'd6000;
	localparam logic [SCALE_W-1:0] ACCEL_SCALE_RST = 24'd1333333;

	localparam logic OP_WRAP = 1'b0;
	localparam logic OP_HALL = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SPD_DIV,
		ST_MUL,
		ST_ACC_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} div_ctl_t;

endpackage

FILE: sv/hpt_serial_div.sv
module hpt_serial_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  hpt_pkg::div_ctl_t        ctl,
	input  logic [hpt_pkg::DIV_W-1:0]    dividend,
	input  logic [hpt_pkg::PERIOD_W-1:0] divisor,
	output logic                     done,
	output logic [hpt_pkg::DIV_W-1:0]    quotient
);
	import hpt_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   cnt_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [PERIOD_W-1:0] dsr_q;
	logic [DIV_W-1:0]    dvd_q;

	logic [PERIOD_W:0]   trial;
	logic [PERIOD_W+1:0] diff;
	logic                ge;

	// One restoring step: bring down the next dividend bit and try the subtract.
	// The quotient bits shift into the dividend register from the bottom.
	always_comb begin
		trial = {rem_q, dvd_q[DIV_W-1]};
		diff  = {1'b0, trial} - {2'b00, dsr_q};
		ge    = ~diff[PERIOD_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

FILE: sv/hpt_serial_mul.sv
module hpt_serial_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [hpt_pkg::SPD_W-1:0]   mcand,
	input  logic [hpt_pkg::SCALE_W-1:0] mplier,
	output logic                        done,
	output logic [hpt_pkg::PROD_W-1:0]  product
);
	import hpt_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic [SPD_W-1:0]     a_q;
	logic [SPD_W-1:0]     hi_q;
	logic [SCALE_W-1:0]   lo_q;
	logic [SPD_W:0]       sum;

	// Shift-add, one multiplier bit per cycle; the low half of the product
	// fills the multiplier register as its bits are used up.
	always_comb begin
		sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= MUL_CNT_W'(SCALE_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - MUL_CNT_W'(1);
				if (cnt_q == MUL_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= mcand;
			hi_q <= '0;
			lo_q <= mplier;
		end else if (busy_q) begin
			hi_q <= sum[SPD_W:1];
			lo_q <= {sum[0], lo_q[SCALE_W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = {hi_q, lo_q};

endmodule

FILE: sv/hall_period_tachometer_top.sv
// Hall-sensor period tachometer.
// The input stream carries two kinds of request, told apart by s_tuser: a timer
// wrap tick (s_tuser = 0) and a Hall edge (s_tuser = 1) whose s_tdata holds the
// free-running timer count captured at the edge. A wrap tick only bumps the
// wrap counter and produces no result. A Hall edge produces exactly one result
// on the output stream: speed and acceleration in m_tdata, the rejected flag in
// m_tuser. A Hall edge runs a 40-step serial division for the speed, a 24-step
// serial multiply and a 48-step serial division for the acceleration, one bit
// a cycle, both divisions in one shared divider; a zero period skips all three,
// and a speed above the limit skips the multiply and the second division. The
// next request is taken once the block is back in idle; s_tready is low while
// an edge is being worked on.
// A finished result sits in the output register; if the receiver stalls, the
// block still takes the next request, then waits with s_tready low to emit it.
// Reset clears the wrap counter, the stored capture, speed and output valid,
// and loads the registers with their default values.
// Registers on the APB port: 0x0 speed numerator, 0x4 speed limit, 0x8
// acceleration scale; write them only while no request is in progress.
module hall_period_tachometer_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [hpt_pkg::IN_TDATA_W-1:0]     s_tdata,  // [15:0] timer_count
	input  logic                               s_tuser,  // [0] operation
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [hpt_pkg::OUT_TDATA_W-1:0]    m_tdata,  // [23:0] speed_rpm,
	                                                     // [49:24] acceleration, zero pad
	output logic                               m_tuser,  // [0] rejected
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [hpt_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [hpt_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [hpt_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready
);
	import hpt_pkg::*;

	localparam logic [DIV_W-1:0] ACC_POS_LIM = (DIV_W'(1) << (ACC_W - 1)) - DIV_W'(1);
	localparam logic [DIV_W-1:0] ACC_NEG_LIM = DIV_W'(1) << (ACC_W - 1);
	localparam logic [SPD_DVD_W-1:0] SPEED_MAX = SPD_DVD_W'({SPD_W{1'b1}});

	state_t state_q, state_d;

	logic [NUM_W-1:0]   speed_num_q;
	logic [LIM_W-1:0]   speed_lim_q;
	logic [SCALE_W-1:0] accel_scale_q;

	logic [WRAP_W-1:0]   wrap_q;
	logic [TIMER_W-1:0]  last_cap_q;
	logic [WRAP_W-1:0]   last_wrap_q;
	logic [SPD_W-1:0]    speed_q;
	logic [PERIOD_W-1:0] period_q;
	logic                neg_q;
	logic [ACC_W-1:0]    acc_q;
	logic                rej_q;

	logic                m_tvalid_q;
	logic [SPD_W-1:0]    m_speed_q;
	logic [ACC_W-1:0]    m_acc_q;
	logic                m_rej_q;

	logic                cfg_wr;
	logic                in_acc;
	logic                hall_acc;
	logic [PERIOD_W-1:0] cnt_diff;
	logic [WRAP_W-1:0]   wrap_diff;
	logic [PERIOD_W-1:0] period_c;

	div_ctl_t            div_ctl;
	logic [DIV_W-1:0]    div_dvd;
	logic [PERIOD_W-1:0] div_dsr;
	logic                div_done;
	logic [DIV_W-1:0]    div_quot;

	logic                mul_start;
	logic                mul_done;
	logic [PROD_W-1:0]   mul_prod;

	logic [SPD_DVD_W-1:0] sp_raw;
	logic [SPD_DVD_W-1:0] lim_fx;
	logic                 sp_over;
	logic [SPD_W-1:0]     sp_new;
	logic                 sp_neg;
	logic [SPD_W-1:0]     sp_mag;
	logic [DIV_W-1:0]     q_neg;
	logic [ACC_W-1:0]     acc_c;
	logic                 out_load;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_num_q   <= SPEED_NUM_RST;
			speed_lim_q   <= SPEED_LIM_RST;
			accel_scale_q <= ACCEL_SCALE_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_SPEED_NUM:   speed_num_q   <= pwdata[NUM_W-1:0];
				REG_SPEED_LIM:   speed_lim_q   <= pwdata[LIM_W-1:0];
				REG_ACCEL_SCALE: accel_scale_q <= pwdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SPEED_NUM:   prdata = APB_DATA_W'(speed_num_q);
			REG_SPEED_LIM:   prdata = APB_DATA_W'(speed_lim_q);
			REG_ACCEL_SCALE: prdata = APB_DATA_W'(accel_scale_q);
			default:         prdata = '0;
		endcase
	end

	// ---------------- datapath helpers ----------------
	assign in_acc   = s_tvalid & s_tready;
	assign hall_acc = in_acc & (s_tuser == OP_HALL);

	always_comb begin
		cnt_diff  = PERIOD_W'(s_tdata[TIMER_W-1:0]) - PERIOD_W'(last_cap_q);
		wrap_diff = wrap_q - last_wrap_q;
		period_c  = cnt_diff + PERIOD_W'(wrap_diff << COUNTER_BITS);
	end

	always_comb begin
		sp_raw  = div_quot[SPD_DVD_W-1:0];
		lim_fx  = SPD_DVD_W'(speed_lim_q) << FRACTION_BITS;
		sp_over = sp_raw > lim_fx;
		sp_new  = (sp_raw > SPEED_MAX) ? {SPD_W{1'b1}} : sp_raw[SPD_W-1:0];
		sp_neg  = sp_new < speed_q;
		sp_mag  = sp_neg ? (speed_q - sp_new) : (sp_new - speed_q);
	end

	always_comb begin
		q_neg = -div_quot;
		if (neg_q) begin
			acc_c = (div_quot > ACC_NEG_LIM) ? ACC_NEG_LIM[ACC_W-1:0] : q_neg[ACC_W-1:0];
		end else begin
			acc_c = (div_quot > ACC_POS_LIM) ? ACC_POS_LIM[ACC_W-1:0] : div_quot[ACC_W-1:0];
		end
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_tready      = 1'b0;
		div_ctl.start = 1'b0;
		div_ctl.steps = STEP_W'(SPD_DVD_W);
		div_dvd       = DIV_W'(speed_num_q) << (DIV_W - NUM_W);
		div_dsr       = period_c;
		mul_start     = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (hall_acc) begin
					if (period_c == '0) begin
						state_d = ST_EMIT;
					end else begin
						div_ctl.start = 1'b1;
						state_d       = ST_SPD_DIV;
					end
				end
			end
			ST_SPD_DIV: begin
				if (div_done) begin
					if (sp_over) begin
						state_d = ST_EMIT;
					end else begin
						mul_start = 1'b1;
						state_d   = ST_MUL;
					end
				end
			end
			ST_MUL: begin
				div_dvd       = mul_prod;
				div_dsr       = period_q;
				div_ctl.steps = STEP_W'(DIV_W);
				if (mul_done) begin
					div_ctl.start = 1'b1;
					state_d       = ST_ACC_DIV;
				end
			end
			ST_ACC_DIV: begin
				if (div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------- measurement state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q      <= '0;
			last_cap_q  <= '0;
			last_wrap_q <= '0;
			speed_q     <= '0;
		end else begin
			if (in_acc && (s_tuser == OP_WRAP)) begin
				wrap_q <= wrap_q + WRAP_W'(1);
			end
			if (hall_acc) begin
				last_cap_q  <= s_tdata[TIMER_W-1:0];
				last_wrap_q <= wrap_q;
			end
			if ((state_q == ST_SPD_DIV) && div_done && !sp_over) begin
				speed_q <= sp_new;
			end
		end
	end

	// A rejected edge leaves the speed alone and reports zero acceleration.
	always_ff @(posedge clk) begin
		if (hall_acc) begin
			period_q <= period_c;
			rej_q    <= (period_c == '0);
			acc_q    <= '0;
		end
		if ((state_q == ST_SPD_DIV) && div_done) begin
			rej_q <= sp_over;
			neg_q <= sp_neg;
		end
		if ((state_q == ST_ACC_DIV) && div_done) begin
			acc_q <= acc_c;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_speed_q <= speed_q;
			m_acc_q   <= acc_q;
			m_rej_q   <= rej_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, m_acc_q, m_speed_q};
	assign m_tuser  = m_rej_q;

	// ---------------- arithmetic units ----------------
	hpt_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (div_quot)
	);

	hpt_serial_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (sp_mag),
		.mplier  (accel_scale_q),
		.done    (mul_done),
		.product (mul_prod)
	);

	// ---------------- checks ----------------
	a_hall_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		hall_acc |=> (state_q != ST_IDLE))
		else $error("Hall edge accepted but sequencer stayed idle");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> ((state_q == ST_SPD_DIV) || (state_q == ST_ACC_DIV)))
		else $error("divider finished outside a division state");

	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_MUL))
		else $error("multiplier finished outside the multiply state");

	a_rej_zero_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[SPD_W+ACC_W-1:SPD_W] == '0))
		else $error("rejected result carries nonzero acceleration");

	a_wrap_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (s_tuser == OP_WRAP)) |=> (wrap_q == $past(wrap_q) + WRAP_W'(1)))
		else $error("wrap tick did not advance the wrap counter");

endmodule

FILE: tb/hpt_checker.sv
`timescale 1ns / 100ps

module hpt_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [hpt_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                            s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [hpt_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                            m_tuser,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic                            pready,
	input  logic [hpt_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [hpt_pkg::APB_DATA_W-1:0]  pwdata,
	output int                              errors,
	output int                              pending
);
	import hpt_pkg::*;

	localparam longint ACC_HI = (64'sd1 <<< (ACC_W - 1)) - 1;
	localparam longint ACC_LO = -(64'sd1 <<< (ACC_W - 1));

	typedef struct packed {
		logic [SPD_W-1:0] speed;
		logic [ACC_W-1:0] accel;
		logic             rejected;
	} tach_result_t;

	tach_result_t speed_results_q[$];

	logic [NUM_W-1:0]   numerator;
	logic [LIM_W-1:0]   limit;
	logic [SCALE_W-1:0] scale;
	logic [WRAP_W-1:0]  wraps;
	logic [WRAP_W-1:0]  ref_wraps;
	logic [TIMER_W-1:0] ref_count;
	logic [SPD_W-1:0]   speed_now;

	// Works out the result of one Hall edge and moves the stored references on.
	function automatic tach_result_t hall_edge_result(input logic [TIMER_W-1:0] count);
		logic [PERIOD_W-1:0] period;
		logic [63:0]         quotient;
		logic [63:0]         change;
		logic [63:0]         scaled;
		logic [SPD_W-1:0]    prior;
		longint              accel;
		tach_result_t        res;
		period = PERIOD_W'(count) - PERIOD_W'(ref_count)
			+ ((wraps - ref_wraps) << COUNTER_BITS);
		ref_count = count;
		ref_wraps = wraps;
		prior = speed_now;
		accel = 0;
		res.rejected = 1'b0;
		if (period == 0) begin
			res.rejected = 1'b1;
		end else begin
			quotient = (64'(numerator) << FRACTION_BITS) / 64'(period);
			if (quotient > (64'(limit) << FRACTION_BITS)) begin
				res.rejected = 1'b1;
			end else begin
				speed_now = (quotient > 64'({SPD_W{1'b1}})) ? {SPD_W{1'b1}}
					: quotient[SPD_W-1:0];
				change = (speed_now >= prior) ? 64'(speed_now - prior)
					: 64'(prior - speed_now);
				scaled = change * 64'(scale) / 64'(period);
				// The quotient is truncated toward zero before the sign goes on.
				if (speed_now < prior) begin
					accel = (scaled > 64'(ACC_HI) + 64'd1) ? ACC_LO : -longint'(scaled);
				end else begin
					accel = (scaled > 64'(ACC_HI)) ? ACC_HI : longint'(scaled);
				end
			end
		end
		res.speed = speed_now;
		res.accel = accel[ACC_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tach_result_t want;
		tach_result_t got;
		if (!arst_n) begin
			numerator = SPEED_NUM_RST;
			limit = SPEED_LIM_RST;
			scale = ACCEL_SCALE_RST;
			wraps = '0;
			ref_wraps = '0;
			ref_count = '0;
			speed_now = '0;
			speed_results_q.delete();
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_SPEED_NUM:   numerator = pwdata[NUM_W-1:0];
					REG_SPEED_LIM:   limit = pwdata[LIM_W-1:0];
					REG_ACCEL_SCALE: scale = pwdata[SCALE_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.speed = m_tdata[SPD_W-1:0];
				got.accel = m_tdata[SPD_W +: ACC_W];
				got.rejected = m_tuser;
				if (speed_results_q.size() == 0) begin
					$error("result with no Hall edge outstanding: speed_rpm %0d",
						got.speed);
					errors++;
				end else begin
					want = speed_results_q.pop_front();
					if (got.speed !== want.speed) begin
						$error("speed_rpm: expected %0d, got %0d", want.speed, got.speed);
						errors++;
					end
					if (got.accel !== want.accel) begin
						$error("acceleration: expected %0d, got %0d",
							$signed(want.accel), $signed(got.accel));
						errors++;
					end
					if (got.rejected !== want.rejected) begin
						$error("rejected: expected %0d, got %0d",
							want.rejected, got.rejected);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == OP_WRAP) begin
					wraps = wraps + 1'b1;
				end else begin
					speed_results_q.push_back(hall_edge_result(s_tdata[TIMER_W-1:0]));
				end
			end
			pending = speed_results_q.size();
		end
	end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import hpt_pkg::*;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // [15:0] timer_count
	logic                   s_tuser;   // [0] operation
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // [23:0] speed_rpm, [49:24] acceleration
	logic                   m_tuser;   // [0] rejected
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [APB_ADDR_W-1:0]  paddr;
	logic [APB_DATA_W-1:0]  pwdata;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;

	int                     errors;
	int                     pending;
	int                     tx_idle_pct;
	int                     rx_idle_pct;
	int                     requests_sent;
	logic [TIMER_W-1:0]     last_hall_count;

	hall_period_tachometer_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	hpt_checker tach_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("hall_period_tachometer_top: mismatch");
		$finish;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	task automatic write_register(input logic [1:0] index, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_settings(input logic [31:0] numerator, input logic [31:0] limit,
		input logic [31:0] scale);
		write_register(REG_SPEED_NUM, numerator);
		write_register(REG_SPEED_LIM, limit);
		write_register(REG_ACCEL_SCALE, scale);
	endtask

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_request(input logic op, input logic [TIMER_W-1:0] count);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= count;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		requests_sent++;
		if (op == OP_HALL) last_hall_count = count;
	endtask

	task automatic send_wraps(input int n);
		repeat (n) send_request(OP_WRAP, TIMER_W'($urandom));
	endtask

	// Mostly wrap ticks followed by an edge, as a running motor produces; the rest
	// are edges that come too soon, repeated captures and stray ticks.
	task automatic run_random(input int budget);
		int stop_at;
		int pick;
		stop_at = requests_sent + budget;
		while (requests_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 80) begin
				send_wraps((pick < 60) ? $urandom_range(1, 3) : $urandom_range(4, 24));
				send_request(OP_HALL, TIMER_W'($urandom));
			end else if (pick < 88) begin
				send_request(OP_HALL, TIMER_W'($urandom));
			end else if (pick < 94) begin
				send_request(OP_HALL, last_hall_count);
			end else begin
				send_wraps(1);
			end
		end
	endtask

	// Registers may only change once every Hall edge has produced its result.
	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_WRAP;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		requests_sent = 0;
		last_hall_count = '0;
		tx_idle_pct = 24;
		rx_idle_pct = 80;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		load_settings(SPEED_NUM_RST, SPEED_LIM_RST, ACCEL_SCALE_RST);
		// Right after reset the capture is zero, so this edge sees a zero period.
		send_request(OP_HALL, 16'h0000);
		send_request(OP_HALL, 16'hFFFF);
		send_wraps(2);
		send_request(OP_HALL, 16'hFFFF);
		send_wraps(3);
		send_request(OP_HALL, 16'hFFFF);
		send_request(OP_HALL, 16'hFFFF);
		send_wraps(1);
		send_request(OP_HALL, 16'h0000);
		send_wraps(12);
		send_request(OP_HALL, 16'h8000);
		run_random(225);
		drain();

		load_settings(32'hFFFF_FFFF, 32'd65535, 32'hFF_FFFF);
		run_random(250);
		drain();

		tx_idle_pct = 80;
		rx_idle_pct = 24;
		load_settings(32'd1, 32'd0, 32'd0);
		run_random(150);
		drain();
		load_settings($urandom, $urandom_range(0, 65535), $urandom_range(0, 24'hFF_FFFF));
		run_random(250);
		drain();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		load_settings($urandom_range(32'd100_000_000, 32'd1_000_000_000),
			$urandom_range(1000, 20000), 32'hFF_FFFF);
		run_random(350);
		drain();

		if (errors == 0) begin
			$display("hall_period_tachometer_top: match");
		end else begin
			$display("hall_period_tachometer_top: mismatch");
		end
		$finish;
	end

endmodule
